>>> rtl/nearest_target_in_view_cone_assert.svh
// Assertion macros shared by the nearest-target block.
// Included by the RTL files that check their own control logic; no other dependencies.
`ifndef NEAREST_TARGET_IN_VIEW_CONE_ASSERT_SVH
`define NEAREST_TARGET_IN_VIEW_CONE_ASSERT_SVH
`ifndef SYNTHESIS
`define NTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define NTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define NTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ntc_pkg.sv
// Shared types, constants and helper functions of the nearest-target block.
// Used by every module of the block; depends on nothing else.
package ntc_pkg;

    localparam int COORD_W      = 32;
    localparam int ANGLE_W      = 16;
    localparam int TRIG_F       = 16;
    localparam int TRIG_W       = TRIG_F + 2;
    localparam int PHASE_W      = 17;
    localparam int TAYLOR_TERMS = 6;
    localparam int K_W          = 3;
    localparam int ACC_W        = 34;
    localparam int DOT_W        = 50;
    localparam int LHS_W        = 100;
    localparam int DIVN_W       = 33;
    localparam int DIVD_W       = 8;
    localparam int MUL_OP_W     = 64;
    localparam int MUL_P_W      = 128;

    localparam logic [31:0] PI_Q30  = 32'hC90FDAA2;
    localparam logic [31:0] NONE_ID = 32'hFFFFFFFF;

    typedef enum logic [1:0] {ST_IDLE, ST_GO, ST_WAIT} t_state;

    typedef enum logic [3:0] {
        SP_RANGE, SP_TX, SP_TX2, SP_TS_M, SP_TS_D, SP_TC_M, SP_TC_D, SP_TFIN,
        SP_TH2, SP_UX, SP_UY, SP_DX, SP_DY, SP_AD, SP_TD, SP_DEC
    } t_step;

    typedef enum logic [1:0] {UK_NONE, UK_MUL, UK_DIV} t_unit;

    typedef struct packed {
        logic           load;
        logic           go;
        logic           wb;
        t_step          step;
        logic           ang;
        logic [K_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic hold;
    } t_status;

    // Which shared unit a step occupies.
    function automatic t_unit unit_of(t_step s);
        t_unit u;
        case (s)
            SP_TS_D, SP_TC_D: u = UK_DIV;
            SP_TFIN, SP_DEC:  u = UK_NONE;
            default:          u = UK_MUL;
        endcase
        return u;
    endfunction

    // Divisor of the k-th sine term: (2k)(2k+1).
    function automatic logic [DIVD_W-1:0] sin_div(logic [K_W-1:0] k);
        logic [DIVD_W-1:0] d;
        case (k)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            default: d = 8'd156;
        endcase
        return d;
    endfunction

    // Divisor of the k-th cosine term: (2k-1)(2k).
    function automatic logic [DIVD_W-1:0] cos_div(logic [K_W-1:0] k);
        logic [DIVD_W-1:0] d;
        case (k)
            3'd1:    d = 8'd2;
            3'd2:    d = 8'd12;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd56;
            3'd5:    d = 8'd90;
            default: d = 8'd132;
        endcase
        return d;
    endfunction

    // Q30 series value to the trig format: negative clears, round half up, clamp to one.
    function automatic logic [TRIG_F:0] to_trig(logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] u;
        if (v[ACC_W-1]) begin
            u = '0;
        end else begin
            u = ($unsigned(v) + (ACC_W'(1) << (29 - TRIG_F))) >> (30 - TRIG_F);
        end
        if (u > (ACC_W'(1) << TRIG_F)) begin
            u = ACC_W'(1) << TRIG_F;
        end
        return u[TRIG_F:0];
    endfunction

endpackage

>>> rtl/ntc_mul.sv
// Shared 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Depends on ntc_pkg for operand and product widths.
module ntc_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [ntc_pkg::MUL_OP_W-1:0]  i_a,
    input  logic [ntc_pkg::MUL_OP_W-1:0]  i_b,
    output logic                          o_done,
    output logic [ntc_pkg::MUL_P_W-1:0]   o_p
);
    import ntc_pkg::*;

    localparam int HALF = MUL_OP_W / 2;

    logic [MUL_OP_W-1:0] r_a;
    logic [MUL_OP_W-1:0] r_b;
    logic [MUL_OP_W-1:0] r_pp;
    logic [1:0]          r_sh;
    logic [MUL_P_W-1:0]  r_acc;
    logic                r_busy;
    logic                r_pv;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic [HALF-1:0]     w_ap;
    logic [HALF-1:0]     w_bp;

    // Halves selected by the partial-product counter.
    assign w_ap = r_cnt[1] ? r_a[MUL_OP_W-1:HALF] : r_a[HALF-1:0];
    assign w_bp = r_cnt[0] ? r_b[MUL_OP_W-1:HALF] : r_b[HALF-1:0];

    // Sequencing: four products, each added in the cycle after it is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                r_pv <= !r_cnt[2];
                if (!r_cnt[2]) begin
                    r_cnt <= r_cnt + 3'd1;
                end else if (r_pv) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product register and shifted accumulation.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (!r_cnt[2]) begin
                r_pp <= w_ap * w_bp;
                r_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
            end
            if (r_pv) begin
                r_acc <= r_acc + (MUL_P_W'(r_pp) << (HALF * r_sh));
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> rtl/ntc_div.sv
// Divider for the Taylor term divisors: multiplies by a rounded-up reciprocal.
// Depends on ntc_pkg for dividend and divisor widths.
module ntc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [ntc_pkg::DIVN_W-1:0]  i_n,
    input  logic [ntc_pkg::DIVD_W-1:0]  i_d,
    output logic                        o_done,
    output logic [ntc_pkg::DIVN_W-1:0]  o_q
);
    import ntc_pkg::*;

    // With a dividend below 2^33 and a divisor below 2^8, a 41-bit shift keeps
    // the reciprocal product exact for every dividend.
    localparam int          REC_SH = 41;
    localparam int          LO_W   = 21;
    localparam int          SUM_W  = DIVN_W + REC_SH;
    localparam logic [63:0] R_ONE  = 64'd1 << REC_SH;

    logic                    r_busy;
    logic                    r_done;
    logic [1:0]              r_ph;
    logic [DIVN_W-1:0]       r_n;
    logic [REC_SH-1:0]       r_m;
    logic [DIVN_W+LO_W-1:0]  r_lo;
    logic [SUM_W-LO_W-1:0]   r_hi;
    logic [DIVN_W-1:0]       r_q;
    logic [SUM_W-1:0]        w_sum;

    // Rounded-up reciprocal 2^41 / d of each series divisor; the largest one is the default.
    function automatic logic [REC_SH-1:0] recip(logic [DIVD_W-1:0] d);
        logic [REC_SH-1:0] m;
        case (d)
            8'd2:    m = REC_SH'((R_ONE + 64'd1) / 64'd2);
            8'd6:    m = REC_SH'((R_ONE + 64'd5) / 64'd6);
            8'd12:   m = REC_SH'((R_ONE + 64'd11) / 64'd12);
            8'd20:   m = REC_SH'((R_ONE + 64'd19) / 64'd20);
            8'd30:   m = REC_SH'((R_ONE + 64'd29) / 64'd30);
            8'd42:   m = REC_SH'((R_ONE + 64'd41) / 64'd42);
            8'd56:   m = REC_SH'((R_ONE + 64'd55) / 64'd56);
            8'd72:   m = REC_SH'((R_ONE + 64'd71) / 64'd72);
            8'd90:   m = REC_SH'((R_ONE + 64'd89) / 64'd90);
            8'd110:  m = REC_SH'((R_ONE + 64'd109) / 64'd110);
            8'd132:  m = REC_SH'((R_ONE + 64'd131) / 64'd132);
            default: m = REC_SH'((R_ONE + 64'd155) / 64'd156);
        endcase
        return m;
    endfunction

    // The two partial products joined; the quotient is the part above the shift.
    assign w_sum = {r_hi, LO_W'(0)} + SUM_W'(r_lo);

    // Phase counter: low product, high product, sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand capture and the staged reciprocal multiply.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_n <= i_n;
            r_m <= recip(i_d);
        end else if (r_busy) begin
            case (r_ph)
                2'd0:    r_lo <= (DIVN_W+LO_W)'(r_n) * (DIVN_W+LO_W)'(r_m[LO_W-1:0]);
                2'd1:    r_hi <= (SUM_W-LO_W)'(r_n) * (SUM_W-LO_W)'(r_m[REC_SH-1:LO_W]);
                default: r_q  <= w_sum[SUM_W-1:REC_SH];
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

>>> rtl/ntc_dp.sv
// Datapath: query state, trig series, distance and cone test, result register.
// Depends on ntc_pkg, ntc_mul and ntc_div; steered by the controller command.
module ntc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntc_pkg::t_cmd       i_cmd,
    output ntc_pkg::t_status    o_status,
    input  logic                i_is_cand,
    input  logic                i_last,
    input  logic [31:0]         i_observer_x,
    input  logic [31:0]         i_observer_y,
    input  logic [15:0]         i_observer_yaw,
    input  logic [30:0]         i_view_range,
    input  logic [15:0]         i_view_angle,
    input  logic [31:0]         i_candidate_id,
    input  logic [31:0]         i_candidate_x,
    input  logic [31:0]         i_candidate_y,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_found,
    output logic [31:0]         o_target_id
);
    import ntc_pkg::*;

    // Query state
    logic signed [COORD_W-1:0] r_org_x;
    logic signed [COORD_W-1:0] r_org_y;
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;
    logic signed [TRIG_W-1:0]  r_th;
    logic [32:0]               r_th2;
    logic [63:0]               r_best;
    logic [31:0]               r_best_id;
    logic                      r_found;
    logic [ANGLE_W-1:0]        r_yaw;
    logic [ANGLE_W-1:0]        r_vang;
    logic [COORD_W-2:0]        r_range;
    // Series working registers
    logic [30:0]               r_x;
    logic [31:0]               r_x2;
    logic [31:0]               r_ts;
    logic [31:0]               r_tc;
    logic signed [ACC_W-1:0]   r_s;
    logic signed [ACC_W-1:0]   r_c;
    logic [1:0]                r_q;
    logic [DIVN_W-1:0]         r_divn;
    // Candidate working registers
    logic [31:0]               r_id;
    logic                      r_last;
    logic signed [COORD_W:0]   r_dx;
    logic signed [COORD_W:0]   r_dy;
    logic [63:0]               r_d2;
    logic signed [DOT_W-1:0]   r_dot;
    logic [LHS_W-1:0]          r_lhs;
    logic                      r_le;
    logic                      r_ge;
    // Result register
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [31:0]               r_out_id;

    logic [MUL_OP_W-1:0]       w_ma;
    logic [MUL_OP_W-1:0]       w_mb;
    logic                      w_mul_done;
    logic [MUL_P_W-1:0]        w_p;
    logic                      w_div_done;
    logic [DIVN_W-1:0]         w_dq;
    logic [DIVD_W-1:0]         w_dd;
    logic [PHASE_W-1:0]        w_phase;
    logic signed [COORD_W:0]   w_dx;
    logic signed [COORD_W:0]   w_dy;
    logic [COORD_W:0]          w_ux;
    logic [COORD_W:0]          w_uy;
    logic                      w_near;
    logic [TRIG_F:0]           w_acos;
    logic [TRIG_F:0]           w_asin;
    logic [TRIG_F:0]           w_ath;
    logic [DOT_W-2:0]          w_adot;
    logic signed [DOT_W-1:0]   w_pterm;
    logic signed [ACC_W-1:0]   w_qterm;
    logic [TRIG_F:0]           w_cs;
    logic [TRIG_F:0]           w_sn;
    logic signed [TRIG_W-1:0]  w_c18;
    logic signed [TRIG_W-1:0]  w_s18;
    logic signed [TRIG_W-1:0]  w_co;
    logic signed [TRIG_W-1:0]  w_so;
    logic                      w_cone;
    logic                      w_qual;
    logic                      w_emit;

    // Candidate offsets from the observer, magnitudes and reach test.
    assign w_dx   = $signed({i_candidate_x[COORD_W-1], i_candidate_x[COORD_W-1:0]})
                  - $signed({r_org_x[COORD_W-1], r_org_x});
    assign w_dy   = $signed({i_candidate_y[COORD_W-1], i_candidate_y[COORD_W-1:0]})
                  - $signed({r_org_y[COORD_W-1], r_org_y});
    assign w_ux   = r_dx[COORD_W] ? $unsigned(-r_dx) : $unsigned(r_dx);
    assign w_uy   = r_dy[COORD_W] ? $unsigned(-r_dy) : $unsigned(r_dy);
    assign w_near = (w_ux[COORD_W:31] == '0) && (w_uy[COORD_W:31] == '0);

    // Magnitudes of the signed trig values and of the dot product.
    assign w_acos = r_cos[TRIG_W-1] ? (TRIG_F+1)'(0) - r_cos[TRIG_F:0] : r_cos[TRIG_F:0];
    assign w_asin = r_sin[TRIG_W-1] ? (TRIG_F+1)'(0) - r_sin[TRIG_F:0] : r_sin[TRIG_F:0];
    assign w_ath  = r_th[TRIG_W-1]  ? (TRIG_F+1)'(0) - r_th[TRIG_F:0]  : r_th[TRIG_F:0];
    assign w_adot = r_dot[DOT_W-1] ? (DOT_W-1)'($unsigned(-r_dot))
                                   : (DOT_W-1)'($unsigned(r_dot));

    // Phase of the angle being expanded: facing angle or the half cone.
    assign w_phase = i_cmd.ang ? (PHASE_W'(r_vang) << (PHASE_W - 1 - ANGLE_W))
                               : (PHASE_W'(r_yaw) << (PHASE_W - ANGLE_W));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.step)
            SP_RANGE: begin w_ma = MUL_OP_W'(r_range);         w_mb = MUL_OP_W'(r_range); end
            SP_TX:    begin w_ma = MUL_OP_W'(w_phase[14:0]);   w_mb = MUL_OP_W'(PI_Q30);  end
            SP_TX2:   begin w_ma = MUL_OP_W'(r_x);             w_mb = MUL_OP_W'(r_x);     end
            SP_TS_M:  begin w_ma = MUL_OP_W'(r_ts);            w_mb = MUL_OP_W'(r_x2);    end
            SP_TC_M:  begin w_ma = MUL_OP_W'(r_tc);            w_mb = MUL_OP_W'(r_x2);    end
            SP_TH2:   begin w_ma = MUL_OP_W'(w_ath);           w_mb = MUL_OP_W'(w_ath);   end
            SP_UX:    begin w_ma = MUL_OP_W'(w_ux);            w_mb = MUL_OP_W'(w_ux);    end
            SP_UY:    begin w_ma = MUL_OP_W'(w_uy);            w_mb = MUL_OP_W'(w_uy);    end
            SP_DX:    begin w_ma = MUL_OP_W'(w_acos);          w_mb = MUL_OP_W'(w_ux);    end
            SP_DY:    begin w_ma = MUL_OP_W'(w_asin);          w_mb = MUL_OP_W'(w_uy);    end
            SP_AD:    begin w_ma = MUL_OP_W'(w_adot);          w_mb = MUL_OP_W'(w_adot);  end
            SP_TD:    begin w_ma = MUL_OP_W'(r_th2);           w_mb = r_d2;               end
            default:  begin w_ma = '0;                         w_mb = '0;                 end
        endcase
    end

    assign w_dd = (i_cmd.step == SP_TS_D) ? sin_div(i_cmd.k) : cos_div(i_cmd.k);

    ntc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.go && (unit_of(i_cmd.step) == UK_MUL)),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_p     (w_p)
    );

    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.go && (unit_of(i_cmd.step) == UK_DIV)),
        .i_n     (r_divn),
        .i_d     (w_dd),
        .o_done  (w_div_done),
        .o_q     (w_dq)
    );

    // Signed partial dot term and signed series term.
    assign w_pterm = ((i_cmd.step == SP_DX) ? (r_cos[TRIG_W-1] ^ r_dx[COORD_W])
                                            : (r_sin[TRIG_W-1] ^ r_dy[COORD_W]))
                   ? -$signed(DOT_W'(w_p[DOT_W-2:0])) : $signed(DOT_W'(w_p[DOT_W-2:0]));
    assign w_qterm = $signed(ACC_W'(w_dq[31:0]));

    // Series result mapped into its quadrant.
    assign w_cs  = to_trig(r_c);
    assign w_sn  = to_trig(r_s);
    assign w_c18 = $signed({1'b0, w_cs});
    assign w_s18 = $signed({1'b0, w_sn});
    always_comb begin
        case (r_q)
            2'd0:    begin w_co = w_c18;  w_so = w_s18;  end
            2'd1:    begin w_co = -w_s18; w_so = w_c18;  end
            2'd2:    begin w_co = -w_c18; w_so = -w_s18; end
            default: begin w_co = w_s18;  w_so = -w_c18; end
        endcase
    end

    // Cone and nearest test; a candidate on the observer is always visible.
    always_comb begin
        if (r_th[TRIG_W-1] || (r_th == '0)) begin
            w_cone = !r_dot[DOT_W-1] || r_le;
        end else begin
            w_cone = !r_dot[DOT_W-1] && (r_dot != '0) && r_ge;
        end
        w_qual = w_near && (r_d2 < r_best) && ((r_d2 == '0) || w_cone);
    end

    // A result word is written by the decision step of a last candidate.
    assign w_emit = i_cmd.wb && (i_cmd.step == SP_DEC) && r_last;

    // Query state: reset, start load and best update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_cos       <= '0;
            r_sin       <= '0;
            r_th        <= '0;
            r_best      <= '0;
            r_best_id   <= NONE_ID;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load && !i_is_cand) begin
                r_org_x <= $signed(i_observer_x[COORD_W-1:0]);
                r_org_y <= $signed(i_observer_y[COORD_W-1:0]);
            end
            if (i_cmd.wb) begin
                case (i_cmd.step)
                    SP_RANGE: begin
                        r_best    <= w_p[63:0];
                        r_best_id <= NONE_ID;
                        r_found   <= 1'b0;
                    end
                    SP_TFIN: begin
                        if (!i_cmd.ang) begin
                            r_cos <= w_co;
                            r_sin <= w_so;
                        end else begin
                            r_th <= w_co;
                        end
                    end
                    SP_DEC: begin
                        if (r_last) begin
                            r_out_valid <= 1'b1;
                            r_out_found <= r_found || w_qual;
                            r_out_id    <= w_qual ? r_id : r_best_id;
                            r_best      <= '0;
                            r_best_id   <= NONE_ID;
                            r_found     <= 1'b0;
                        end else if (w_qual) begin
                            r_best    <= r_d2;
                            r_best_id <= r_id;
                            r_found   <= 1'b1;
                        end
                    end
                    default: begin
                        r_found <= r_found;
                    end
                endcase
            end
        end
    end

    // Working registers: input capture and per-step write back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_is_cand && i_last;
            if (!i_is_cand) begin
                r_yaw   <= i_observer_yaw[ANGLE_W-1:0];
                r_vang  <= i_view_angle[ANGLE_W-1:0];
                r_range <= i_view_range[COORD_W-2:0];
            end else begin
                r_id <= i_candidate_id;
                r_dx <= w_dx;
                r_dy <= w_dy;
            end
        end
        if (i_cmd.wb) begin
            case (i_cmd.step)
                SP_TX: begin
                    r_x  <= w_p[46:16];
                    r_ts <= {1'b0, w_p[46:16]};
                    r_tc <= 32'h4000_0000;
                    r_s  <= $signed(ACC_W'(w_p[46:16]));
                    r_c  <= $signed(ACC_W'(32'h4000_0000));
                    r_q  <= w_phase[PHASE_W-1:PHASE_W-2];
                end
                SP_TX2:  r_x2 <= w_p[61:30];
                SP_TS_M: r_divn <= w_p[62:30];
                SP_TC_M: r_divn <= w_p[62:30];
                SP_TS_D: begin
                    r_ts <= w_dq[31:0];
                    r_s  <= i_cmd.k[0] ? r_s - w_qterm : r_s + w_qterm;
                end
                SP_TC_D: begin
                    r_tc <= w_dq[31:0];
                    r_c  <= i_cmd.k[0] ? r_c - w_qterm : r_c + w_qterm;
                end
                SP_TH2:  r_th2 <= w_p[32:0];
                SP_UX:   r_d2 <= w_p[63:0];
                SP_UY:   r_d2 <= r_d2 + w_p[63:0];
                SP_DX:   r_dot <= w_pterm;
                SP_DY:   r_dot <= r_dot + w_pterm;
                SP_AD:   r_lhs <= w_p[LHS_W-1:0];
                SP_TD: begin
                    r_le <= MUL_P_W'(r_lhs) <= w_p;
                    r_ge <= MUL_P_W'(r_lhs) >= w_p;
                end
                default: r_q <= r_q;
            endcase
        end
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.div_done = w_div_done;
    assign o_status.hold     = r_last && r_out_valid && !i_ready;

    assign o_valid     = r_out_valid;
    assign o_found     = r_out_found;
    assign o_target_id = r_out_id;

endmodule

>>> rtl/ntc_ctrl.sv
// Controller: walks the step sequence of a start word or a candidate word.
// Depends on ntc_pkg and the assertion macro header.
`include "nearest_target_in_view_cone_assert.svh"
module ntc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_is_cand,
    output logic              o_ready,
    input  ntc_pkg::t_status  i_status,
    output ntc_pkg::t_cmd     o_cmd
);
    import ntc_pkg::*;

    t_state         r_state;
    t_state         n_state;
    t_step          r_step;
    t_step          n_step;
    logic           r_ang;
    logic           n_ang;
    logic [K_W-1:0] r_k;
    logic [K_W-1:0] n_k;
    t_step          w_nstep;
    logic           w_nang;
    logic [K_W-1:0] w_nk;
    logic           w_end;
    logic           w_done;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= SP_RANGE;
            r_ang   <= 1'b0;
            r_k     <= K_W'(1);
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ang   <= n_ang;
            r_k     <= n_k;
        end
    end

    // Successor of the current step, with the series loop and the two angles.
    always_comb begin
        w_nstep = r_step;
        w_nang  = r_ang;
        w_nk    = r_k;
        w_end   = 1'b0;
        case (r_step)
            SP_RANGE: w_nstep = SP_TX;
            SP_TX:    w_nstep = SP_TX2;
            SP_TX2:   w_nstep = SP_TS_M;
            SP_TS_M:  w_nstep = SP_TS_D;
            SP_TS_D:  w_nstep = SP_TC_M;
            SP_TC_M:  w_nstep = SP_TC_D;
            SP_TC_D: begin
                if (r_k == K_W'(TAYLOR_TERMS)) begin
                    w_nstep = SP_TFIN;
                end else begin
                    w_nk    = r_k + K_W'(1);
                    w_nstep = SP_TS_M;
                end
            end
            SP_TFIN: begin
                if (!r_ang) begin
                    w_nang  = 1'b1;
                    w_nk    = K_W'(1);
                    w_nstep = SP_TX;
                end else begin
                    w_nstep = SP_TH2;
                end
            end
            SP_UX:   w_nstep = SP_UY;
            SP_UY:   w_nstep = SP_DX;
            SP_DX:   w_nstep = SP_DY;
            SP_DY:   w_nstep = SP_AD;
            SP_AD:   w_nstep = SP_TD;
            SP_TD:   w_nstep = SP_DEC;
            default: w_end = 1'b1;
        endcase
    end

    assign w_done = (unit_of(r_step) == UK_DIV) ? i_status.div_done : i_status.mul_done;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_ang       = r_ang;
        n_k         = r_k;
        o_ready     = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.go    = 1'b0;
        o_cmd.wb    = 1'b0;
        o_cmd.step  = r_step;
        o_cmd.ang   = r_ang;
        o_cmd.k     = r_k;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = i_is_cand ? SP_UX : SP_RANGE;
                    n_ang      = 1'b0;
                    n_k        = K_W'(1);
                    n_state    = ST_GO;
                end
            end
            ST_GO: begin
                if (unit_of(r_step) != UK_NONE) begin
                    o_cmd.go = 1'b1;
                    n_state  = ST_WAIT;
                end else if (!((r_step == SP_DEC) && i_status.hold)) begin
                    o_cmd.wb = 1'b1;
                    n_step   = w_nstep;
                    n_ang    = w_nang;
                    n_k      = w_nk;
                    n_state  = w_end ? ST_IDLE : ST_GO;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    o_cmd.wb = 1'b1;
                    n_step   = w_nstep;
                    n_ang    = w_nang;
                    n_k      = w_nk;
                    n_state  = w_end ? ST_IDLE : ST_GO;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // A unit wait only ever follows a step that uses a unit.
    `NTC_ASSERT_IMP(a_wait_unit, i_clk, i_rst_n, r_state == ST_WAIT, unit_of(r_step) != UK_NONE)
    // A started unit is always waited for.
    `NTC_ASSERT_NXT(a_go_waits, i_clk, i_rst_n, o_cmd.go, r_state == ST_WAIT)
    // The series term index stays within the expansion.
    `NTC_ASSERT_IMP(a_k_range, i_clk, i_rst_n, r_state != ST_IDLE, (r_k >= K_W'(1)) && (r_k <= K_W'(TAYLOR_TERMS)))
    // A result is never written over one that is still waiting.
    `NTC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.wb && (r_step == SP_DEC), !i_status.hold)

endmodule

>>> rtl/nearest_target_in_view_cone.sv
// Nearest visible target in a view cone: one word at a time. A start word
// expands the cosine and sine of the facing and half cone angles by Taylor
// series; each of its 24 series terms takes one pass of the shared 64 x 64
// multiplier (four 32 x 32 partial products) and one pass of the reciprocal
// divider (two partial products and a sum). A candidate word takes six
// multiplier passes (squares, dot product, exact cone compare) and a decision
// step. The result word waits in an output register, so the next input word is
// taken while it is still unread; only the next last candidate stalls until the
// waiting word has been read.
// Depends on ntc_pkg, ntc_ctrl and ntc_dp.
module nearest_target_in_view_cone (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // observer_x, observer_y, observer_yaw, view_range, view_angle,
    // candidate_id, candidate_x, candidate_y, one pad bit
    input  logic [223:0] s_axis_tdata,
    // cmd
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // target_id
    output logic [31:0]  m_axis_tdata,
    // found
    output logic [0:0]   m_axis_tuser
);
    import ntc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_found;

    ntc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_is_cand (s_axis_tuser[0]),
        .o_ready   (s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    ntc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_is_cand      (s_axis_tuser[0]),
        .i_last         (s_axis_tlast),
        .i_observer_x   (s_axis_tdata[31:0]),
        .i_observer_y   (s_axis_tdata[63:32]),
        .i_observer_yaw (s_axis_tdata[79:64]),
        .i_view_range   (s_axis_tdata[110:80]),
        .i_view_angle   (s_axis_tdata[126:111]),
        .i_candidate_id (s_axis_tdata[158:127]),
        .i_candidate_x  (s_axis_tdata[190:159]),
        .i_candidate_y  (s_axis_tdata[222:191]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_found        (w_found),
        .o_target_id    (m_axis_tdata)
    );

    assign m_axis_tuser = w_found;

endmodule
